### rtl/dms_pkg.sv
// dms_pkg: shared types and codes for the display mode sequencer.
// No dependencies; used by dms_step, display_mode_sequencer and dms_checker.
`default_nettype none

package dms_pkg;

  // Operating modes of the sequencer
  typedef enum logic [3:0] {
    MODE_INIT    = 4'd0,
    MODE_IDLE    = 4'd1,
    MODE_PSAVE   = 4'd2,
    MODE_WRITE   = 4'd3,
    MODE_CLEAR   = 4'd4,
    MODE_LPENTER = 4'd5,
    MODE_LP      = 4'd6,
    MODE_LPEXIT  = 4'd7,
    MODE_FAULT   = 4'd8,
    MODE_RESET   = 4'd9
  } mode_t;

  // Action codes carried on in_tuser
  localparam logic [3:0] ACT_TICK       = 4'd0;
  localparam logic [3:0] ACT_SET_PSAVE  = 4'd1;
  localparam logic [3:0] ACT_CLR_PSAVE  = 4'd2;
  localparam logic [3:0] ACT_WAKE       = 4'd3;
  localparam logic [3:0] ACT_SET_WRITE  = 4'd4;
  localparam logic [3:0] ACT_SET_CLEAR  = 4'd5;
  localparam logic [3:0] ACT_SET_LOWPWR = 4'd6;
  localparam logic [3:0] ACT_CLR_LOWPWR = 4'd7;
  localparam logic [3:0] ACT_SET_RESET  = 4'd8;

  // Request flag bit positions
  localparam int FLG_PSAVE  = 0;
  localparam int FLG_WRITE  = 1;
  localparam int FLG_CLEAR  = 2;
  localparam int FLG_LOWPWR = 3;
  localparam int FLG_RESET  = 4;
  localparam int FLG_START  = 5;
  localparam int FLAG_W     = 6;

  localparam logic [FLAG_W-1:0] FLAGS_RESET_VAL = 6'b10_0000;

  // Backlight / display command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Fixed port field widths
  localparam int LINES_W  = 4;
  localparam int STATUS_W = 8;
  localparam int FAULT_W  = 8;
  localparam int SLEEP_W  = 32;

  // Control state other than the fault code
  typedef struct packed {
    mode_t               mode;
    logic [FLAG_W-1:0]   flags;
    logic [SLEEP_W-1:0]  sleep_cnt;
    logic                restart;
  } ctl_state_t;

  // Commands issued for one item
  typedef struct packed {
    logic [1:0]          backlight_cmd;
    logic [1:0]          display_cmd;
    logic                clear_screen;
    logic [LINES_W-1:0]  send_lines;
    logic                reinit;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/dms_step.sv
// dms_step: combinational update for one item: flag changes, fault merge,
// mode choice and command generation. Depends on dms_pkg.
`default_nettype none

module dms_step #(
  parameter int LINE_COUNT = 4,
  parameter int FAULT_BITS = 8
) (
  input  wire logic [3:0]                  action,
  input  wire logic [dms_pkg::STATUS_W-1:0] driver_status,
  input  wire logic [dms_pkg::LINES_W-1:0]  dirty_lines,
  input  wire logic [dms_pkg::SLEEP_W-1:0]  sleep_ticks,
  input  wire dms_pkg::ctl_state_t          st,
  input  wire logic [FAULT_BITS-1:0]       fault_in,
  output dms_pkg::ctl_state_t               st_nxt,
  output logic [FAULT_BITS-1:0]            fault_nxt,
  output logic [dms_pkg::FAULT_W-1:0]       fault_value,
  output dms_pkg::cmd_t                     cmd
);
  import dms_pkg::*;

  // Common width for merging status into the fault code
  localparam int MW = (FAULT_BITS > STATUS_W) ? FAULT_BITS :
                      ((FAULT_BITS > FAULT_W) ? FAULT_BITS : STATUS_W);

  logic [MW-1:0]          merge_w;
  logic [FAULT_BITS-1:0]  fault_or;
  logic                   flt;
  mode_t                  next_mode;
  logic [SLEEP_W-1:0]     cnt_upd;
  logic [LINES_W-1:0]     line_mask;
  logic [MW-1:0]          fault_out_w;

  // Sticky fault merge, kept to FAULT_BITS
  assign merge_w  = MW'(fault_in) | MW'(driver_status);
  assign fault_or = merge_w[FAULT_BITS-1:0];
  assign flt      = (fault_or != '0);

  // Only lines below LINE_COUNT may be sent
  always_comb begin
    for (int i = 0; i < LINES_W; i++) begin
      line_mask[i] = (i < LINE_COUNT);
    end
  end

  // Saturating sleep counter step
  always_comb begin
    if (st.restart) begin
      cnt_upd = '0;
    end else if (st.sleep_cnt == {SLEEP_W{1'b1}}) begin
      cnt_upd = st.sleep_cnt;
    end else begin
      cnt_upd = st.sleep_cnt + SLEEP_W'(1);
    end
  end

  // Priority rules for the mode taken on a tick
  always_comb begin
    unique case (st.mode)
      MODE_INIT: next_mode = st.flags[FLG_START] ? MODE_INIT : MODE_IDLE;
      MODE_IDLE: begin
        priority if (st.flags[FLG_RESET])  next_mode = MODE_RESET;
        else if (st.flags[FLG_LOWPWR])     next_mode = MODE_LPENTER;
        else if (st.flags[FLG_PSAVE])      next_mode = MODE_PSAVE;
        else if (st.flags[FLG_WRITE])      next_mode = MODE_WRITE;
        else if (st.flags[FLG_CLEAR])      next_mode = MODE_CLEAR;
        else                               next_mode = MODE_IDLE;
      end
      MODE_PSAVE: begin
        priority if (st.flags[FLG_RESET])  next_mode = MODE_RESET;
        else if (st.flags[FLG_LOWPWR])     next_mode = MODE_LPENTER;
        else if (st.flags[FLG_WRITE])      next_mode = MODE_WRITE;
        else if (st.flags[FLG_CLEAR])      next_mode = MODE_CLEAR;
        else if (!st.flags[FLG_PSAVE])     next_mode = MODE_IDLE;
        else                               next_mode = MODE_PSAVE;
      end
      MODE_WRITE, MODE_LPEXIT: begin
        priority if (flt)                  next_mode = MODE_FAULT;
        else if (st.flags[FLG_RESET])      next_mode = MODE_RESET;
        else if (st.flags[FLG_PSAVE])      next_mode = MODE_PSAVE;
        else                               next_mode = MODE_IDLE;
      end
      MODE_CLEAR: begin
        priority if (flt)                  next_mode = MODE_FAULT;
        else if (st.flags[FLG_RESET])      next_mode = MODE_RESET;
        else if (st.flags[FLG_PSAVE])      next_mode = MODE_PSAVE;
        else if (!st.flags[FLG_CLEAR])     next_mode = MODE_IDLE;
        else                               next_mode = MODE_CLEAR;
      end
      MODE_LPENTER: next_mode = MODE_LP;
      MODE_LP: begin
        if (flt || st.flags[FLG_RESET] || !st.flags[FLG_LOWPWR]) begin
          next_mode = MODE_LPEXIT;
        end else begin
          next_mode = MODE_LP;
        end
      end
      MODE_FAULT: begin
        priority if (st.flags[FLG_RESET])  next_mode = MODE_RESET;
        else if (!flt)                     next_mode = st.flags[FLG_PSAVE] ?
                                                       MODE_PSAVE : MODE_IDLE;
        else                               next_mode = MODE_FAULT;
      end
      MODE_RESET: next_mode = MODE_INIT;
      default:    next_mode = MODE_INIT;
    endcase
  end

  // Apply the item: events touch flags, ticks move the mode
  always_comb begin
    st_nxt    = st;
    fault_nxt = fault_in;
    cmd       = '0;
    unique case (action)
      ACT_TICK: begin
        fault_nxt   = fault_or;
        st_nxt.mode = next_mode;
        unique case (next_mode)
          MODE_INIT: begin
            st_nxt.flags[FLG_RESET] = 1'b0;
            st_nxt.flags[FLG_START] = 1'b0;
          end
          MODE_PSAVE: begin
            st_nxt.sleep_cnt = cnt_upd;
            st_nxt.restart   = 1'b0;
            if (cnt_upd >= sleep_ticks) begin
              st_nxt.restart    = 1'b1;
              cmd.backlight_cmd = CMD_OFF;
            end
          end
          MODE_WRITE: begin
            cmd.send_lines          = dirty_lines & line_mask;
            st_nxt.flags[FLG_WRITE] = 1'b0;
          end
          MODE_CLEAR: begin
            cmd.clear_screen        = 1'b1;
            st_nxt.flags[FLG_CLEAR] = 1'b0;
          end
          MODE_LPENTER: begin
            cmd.clear_screen  = 1'b1;
            cmd.backlight_cmd = CMD_OFF;
            cmd.display_cmd   = CMD_OFF;
          end
          MODE_LPEXIT: begin
            cmd.display_cmd          = CMD_ON;
            cmd.backlight_cmd        = CMD_ON;
            st_nxt.flags[FLG_LOWPWR] = 1'b0;
          end
          MODE_RESET: begin
            fault_nxt  = '0;
            cmd.reinit = 1'b1;
          end
          default: ;
        endcase
      end
      ACT_SET_PSAVE:  st_nxt.flags[FLG_PSAVE] = 1'b1;
      ACT_CLR_PSAVE: begin
        st_nxt.flags[FLG_PSAVE] = 1'b0;
        st_nxt.restart          = 1'b1;
        cmd.backlight_cmd       = CMD_ON;
      end
      ACT_WAKE: begin
        st_nxt.restart    = 1'b1;
        cmd.backlight_cmd = CMD_ON;
      end
      ACT_SET_WRITE:  st_nxt.flags[FLG_WRITE]  = 1'b1;
      ACT_SET_CLEAR:  st_nxt.flags[FLG_CLEAR]  = 1'b1;
      ACT_SET_LOWPWR: st_nxt.flags[FLG_LOWPWR] = 1'b1;
      ACT_CLR_LOWPWR: st_nxt.flags[FLG_LOWPWR] = 1'b0;
      ACT_SET_RESET:  st_nxt.flags[FLG_RESET]  = 1'b1;
      default: ;
    endcase
  end

  // Reported fault: low byte of the stored code
  assign fault_out_w = MW'(fault_nxt);
  assign fault_value = fault_out_w[FAULT_W-1:0];

endmodule

`default_nettype wire

### rtl/display_mode_sequencer.sv
// display_mode_sequencer: top level with input register, state and result register.
// Depends on dms_pkg and dms_step.
`default_nettype none

// Ten-mode sequencer for a character display. Each transfer on the input
// stream (action on in_tuser, driver status and line bits on in_tdata)
// yields exactly one result transfer carrying the mode, the sticky fault
// code and the backlight, display, clear, line-send and re-init commands.
// An item goes from the input register through one pass of the step logic
// into the result register, and a new item is taken every cycle as long as
// the result side keeps up. sleep_ticks is written on the cfg_ channel,
// which is always ready; write it while the stream is idle. After reset the
// block starts in init mode with the startup request set, so the first tick
// stays in init and the second moves to idle.
module display_mode_sequencer #(
  parameter int LINE_COUNT = 4,
  parameter int FAULT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] driver_status, [11:8] dirty_lines, [15:12] 0
  input  wire logic [3:0]  in_tuser,   // [3:0] action
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] mode, [11:4] fault_value,
                                       // [13:12] backlight_cmd, [15:14] display_cmd,
                                       // [16] clear_screen, [20:17] send_lines,
                                       // [21] reinit, [23:22] 0
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // sleep_ticks
);
  import dms_pkg::*;

  // Input register
  logic                 in_valid_r;
  logic [3:0]           act_r;
  logic [STATUS_W-1:0]  status_r;
  logic [LINES_W-1:0]   lines_r;

  // Block state
  ctl_state_t             st_r;
  logic [FAULT_BITS-1:0]  fault_r;
  logic [SLEEP_W-1:0]     sleep_ticks_r;

  // Result register
  logic                 out_valid_r;
  mode_t                res_mode_r;
  logic [FAULT_W-1:0]   res_fault_r;
  cmd_t                 res_cmd_r;

  ctl_state_t             st_nxt;
  logic [FAULT_BITS-1:0]  fault_nxt;
  logic [FAULT_W-1:0]     fault_value;
  cmd_t                   cmd;
  logic                   advance;

  // Item in the input register moves on when the result slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  dms_step #(
    .LINE_COUNT (LINE_COUNT),
    .FAULT_BITS (FAULT_BITS)
  ) u_step (
    .action        (act_r),
    .driver_status (status_r),
    .dirty_lines   (lines_r),
    .sleep_ticks   (sleep_ticks_r),
    .st            (st_r),
    .fault_in      (fault_r),
    .st_nxt        (st_nxt),
    .fault_nxt     (fault_nxt),
    .fault_value   (fault_value),
    .cmd           (cmd)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      act_r    <= in_tuser;
      status_r <= in_tdata[STATUS_W-1:0];
      lines_r  <= in_tdata[STATUS_W +: LINES_W];
    end
  end

  // Sequencer state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= MODE_INIT;
      st_r.flags     <= FLAGS_RESET_VAL;
      st_r.sleep_cnt <= '0;
      st_r.restart   <= 1'b1;
      fault_r        <= '0;
      sleep_ticks_r  <= '0;
    end else begin
      if (advance) begin
        st_r    <= st_nxt;
        fault_r <= fault_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        sleep_ticks_r <= cfg_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      res_mode_r  <= st_nxt.mode;
      res_fault_r <= fault_value;
      res_cmd_r   <= cmd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       res_cmd_r.reinit,
                       res_cmd_r.send_lines,
                       res_cmd_r.clear_screen,
                       res_cmd_r.display_cmd,
                       res_cmd_r.backlight_cmd,
                       res_fault_r,
                       res_mode_r};

endmodule

`default_nettype wire

### rtl/dms_checker.sv
// dms_checker: port-level checks on the display mode sequencer, bound to the top.
// Depends on dms_pkg and display_mode_sequencer.
`default_nettype none

module dms_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  import dms_pkg::*;

  logic [3:0] mode_f;
  logic [7:0] fault_f;
  logic [1:0] bl_f;
  logic [1:0] disp_f;
  logic       clr_f;
  logic [3:0] send_f;
  logic       reinit_f;

  assign mode_f   = out_tdata[3:0];
  assign fault_f  = out_tdata[11:4];
  assign bl_f     = out_tdata[13:12];
  assign disp_f   = out_tdata[15:14];
  assign clr_f    = out_tdata[16];
  assign send_f   = out_tdata[20:17];
  assign reinit_f = out_tdata[21];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Re-init only on entry to reset mode, with the fault code cleared
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && reinit_f |-> mode_f == MODE_RESET && fault_f == 8'd0)
    else $error("reinit outside reset mode or with fault set");

  // Lines are only sent in write mode
  a_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && send_f != 4'd0 |-> mode_f == MODE_WRITE)
    else $error("lines sent outside write mode");

  // Display off only on low-power entry, with clear and backlight off
  a_disp_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && disp_f == CMD_OFF |->
      mode_f == MODE_LPENTER && clr_f && bl_f == CMD_OFF)
    else $error("display off outside low-power entry");

  // Display on only on low-power exit, with backlight on
  a_disp_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && disp_f == CMD_ON |-> mode_f == MODE_LPEXIT && bl_f == CMD_ON)
    else $error("display on outside low-power exit");

endmodule

bind display_mode_sequencer dms_checker u_dms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for display_mode_sequencer (stream in, stream out, cfg write).
// Depends on dms_pkg and display_mode_sequencer; holds its own mode/flag/timer predictor.

module tb;
  import dms_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 4;

  // One expected result, laid out field by field
  typedef struct packed {
    mode_t              mode;
    logic [FAULT_W-1:0] fault;
    cmd_t               cmd;
  } seq_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  wire         in_tready;
  logic [15:0] in_tdata;   // [7:0] driver_status, [11:8] dirty_lines, [15:12] 0
  logic [3:0]  in_tuser;   // [3:0] action
  wire         out_tvalid;
  logic        out_tready;
  wire  [23:0] out_tdata;  // [3:0] mode, [11:4] fault, [13:12] backlight, [15:14] display,
                           // [16] clear, [20:17] send_lines, [21] reinit, [23:22] 0
  logic        cfg_valid;
  wire         cfg_ready;
  logic [31:0] cfg_data;   // sleep_ticks

  display_mode_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the sequencer state and its one register
  mode_t              sh_mode;
  logic [FAULT_W-1:0] sh_fault;
  logic [FLAG_W-1:0]  sh_flags;
  logic [SLEEP_W-1:0] sh_sleep_cnt;
  logic [SLEEP_W-1:0] sh_sleep_ticks;
  logic               sh_restart;

  seq_result_t exp_results[$];
  int          errors;
  int          n_sent;
  int          cycles;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_len;

  // Priority rules for the mode that follows a tick
  function automatic mode_t pick_next_mode(mode_t m, logic [FLAG_W-1:0] f, logic flt);
    case (m)
      MODE_INIT: return f[FLG_START] ? MODE_INIT : MODE_IDLE;
      MODE_IDLE: begin
        if (f[FLG_RESET]) return MODE_RESET;
        if (f[FLG_LOWPWR]) return MODE_LPENTER;
        if (f[FLG_PSAVE]) return MODE_PSAVE;
        if (f[FLG_WRITE]) return MODE_WRITE;
        if (f[FLG_CLEAR]) return MODE_CLEAR;
        return MODE_IDLE;
      end
      MODE_PSAVE: begin
        if (f[FLG_RESET]) return MODE_RESET;
        if (f[FLG_LOWPWR]) return MODE_LPENTER;
        if (f[FLG_WRITE]) return MODE_WRITE;
        if (f[FLG_CLEAR]) return MODE_CLEAR;
        if (!f[FLG_PSAVE]) return MODE_IDLE;
        return MODE_PSAVE;
      end
      MODE_WRITE, MODE_LPEXIT: begin
        if (flt) return MODE_FAULT;
        if (f[FLG_RESET]) return MODE_RESET;
        if (f[FLG_PSAVE]) return MODE_PSAVE;
        return MODE_IDLE;
      end
      MODE_CLEAR: begin
        if (flt) return MODE_FAULT;
        if (f[FLG_RESET]) return MODE_RESET;
        if (f[FLG_PSAVE]) return MODE_PSAVE;
        if (!f[FLG_CLEAR]) return MODE_IDLE;
        return MODE_CLEAR;
      end
      MODE_LPENTER: return MODE_LP;
      MODE_LP: begin
        if (flt || f[FLG_RESET] || !f[FLG_LOWPWR]) return MODE_LPEXIT;
        return MODE_LP;
      end
      MODE_FAULT: begin
        if (f[FLG_RESET]) return MODE_RESET;
        // fault cleared: back to power save if still requested
        if (!flt) return f[FLG_PSAVE] ? MODE_PSAVE : MODE_IDLE;
        return MODE_FAULT;
      end
      MODE_RESET: return MODE_INIT;
      default: return MODE_INIT;
    endcase
  endfunction

  // Apply one item to the shadow state, return the result it should produce
  function automatic seq_result_t advance_sequencer(logic [3:0] act,
                                                    logic [STATUS_W-1:0] status,
                                                    logic [LINES_W-1:0] lines);
    seq_result_t r;
    mode_t       nxt;
    r = '0;
    case (act)
      ACT_TICK: begin
        sh_fault = sh_fault | status;
        nxt = pick_next_mode(sh_mode, sh_flags, sh_fault != '0);
        case (nxt)
          MODE_INIT: begin
            sh_flags[FLG_RESET] = 1'b0;
            sh_flags[FLG_START] = 1'b0;
          end
          MODE_PSAVE: begin
            // sleep timer: restart or count up, saturating
            if (sh_restart) begin
              sh_restart   = 1'b0;
              sh_sleep_cnt = '0;
            end else if (sh_sleep_cnt != '1) begin
              sh_sleep_cnt = sh_sleep_cnt + 1'b1;
            end
            if (sh_sleep_cnt >= sh_sleep_ticks) begin
              sh_restart = 1'b1;
              r.cmd.backlight_cmd = CMD_OFF;
            end
          end
          MODE_WRITE: begin
            r.cmd.send_lines = lines;
            sh_flags[FLG_WRITE] = 1'b0;
          end
          MODE_CLEAR: begin
            r.cmd.clear_screen = 1'b1;
            sh_flags[FLG_CLEAR] = 1'b0;
          end
          MODE_LPENTER: begin
            r.cmd.clear_screen  = 1'b1;
            r.cmd.backlight_cmd = CMD_OFF;
            r.cmd.display_cmd   = CMD_OFF;
          end
          MODE_LPEXIT: begin
            r.cmd.display_cmd   = CMD_ON;
            r.cmd.backlight_cmd = CMD_ON;
            sh_flags[FLG_LOWPWR] = 1'b0;
          end
          MODE_RESET: begin
            sh_fault = '0;
            r.cmd.reinit = 1'b1;
          end
          default: ;
        endcase
        sh_mode = nxt;
      end
      ACT_SET_PSAVE: sh_flags[FLG_PSAVE] = 1'b1;
      ACT_CLR_PSAVE: begin
        sh_flags[FLG_PSAVE] = 1'b0;
        sh_restart = 1'b1;
        r.cmd.backlight_cmd = CMD_ON;
      end
      ACT_WAKE: begin
        sh_restart = 1'b1;
        r.cmd.backlight_cmd = CMD_ON;
      end
      ACT_SET_WRITE:  sh_flags[FLG_WRITE] = 1'b1;
      ACT_SET_CLEAR:  sh_flags[FLG_CLEAR] = 1'b1;
      ACT_SET_LOWPWR: sh_flags[FLG_LOWPWR] = 1'b1;
      ACT_CLR_LOWPWR: sh_flags[FLG_LOWPWR] = 1'b0;
      ACT_SET_RESET:  sh_flags[FLG_RESET] = 1'b1;
      default: ;  // unused codes change nothing
    endcase
    r.mode  = sh_mode;
    r.fault = sh_fault;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Scoreboard: predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin : scoreboard
    seq_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        exp_results.push_back(advance_sequencer(in_tuser, in_tdata[7:0], in_tdata[11:8]));
      if (out_tvalid && out_tready) begin
        if (exp_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = exp_results.pop_front();
          check_field("mode", want.mode, out_tdata[3:0]);
          check_field("fault_value", want.fault, out_tdata[11:4]);
          check_field("backlight_cmd", want.cmd.backlight_cmd, out_tdata[13:12]);
          check_field("display_cmd", want.cmd.display_cmd, out_tdata[15:14]);
          check_field("clear_screen", want.cmd.clear_screen, out_tdata[16]);
          check_field("send_lines", want.cmd.send_lines, out_tdata[20:17]);
          check_field("reinit", want.cmd.reinit, out_tdata[21]);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Result side: random stalls, plus a long hold when one is requested
  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = idle_len();
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item and wait for its transfer
  task automatic send_item(logic [3:0] act, logic [7:0] status, logic [3:0] lines);
    int gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, lines, status};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic tick(logic [7:0] status, logic [3:0] lines);
    send_item(ACT_TICK, status, lines);
  endtask

  // Tick with a driver status that is mostly clean
  task automatic quiet_tick();
    tick(($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
         4'($urandom));
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sleep_ticks(logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_sleep_ticks = value;
  endtask

  // Walk every mode and action once, field extremes included
  task automatic test_mode_walk();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_sleep_ticks(32'd0);
    tick(8'h00, 4'h0);                       // startup stays in init once
    tick(8'h00, 4'h0);                       // to idle
    send_item(4'd9, 8'hFF, 4'hF);            // unused codes are ignored
    send_item(4'd15, 8'hFF, 4'hF);
    send_item(ACT_SET_PSAVE, 8'h00, 4'h0);
    tick(8'h00, 4'h0);                       // power save, zero timeout: off each tick
    tick(8'h80, 4'h0);                       // fault stored but not examined here
    send_item(ACT_WAKE, 8'h00, 4'h0);
    send_item(ACT_SET_WRITE, 8'h00, 4'h0);
    tick(8'h01, 4'hF);                       // write, all lines
    tick(8'h00, 4'h0);                       // fault set: to fault mode
    tick(8'hFF, 4'h0);
    send_item(ACT_SET_RESET, 8'h00, 4'h0);
    tick(8'h00, 4'h0);                       // reset, fault cleared
    tick(8'h00, 4'h0);
    tick(8'h00, 4'h0);
    tick(8'h00, 4'h0);
    send_item(ACT_CLR_PSAVE, 8'h00, 4'h0);
    send_item(ACT_SET_CLEAR, 8'h00, 4'h0);
    tick(8'h00, 4'h0);
    tick(8'h00, 4'h0);
    send_item(ACT_SET_LOWPWR, 8'h00, 4'h0);
    tick(8'h00, 4'h0);
    tick(8'h00, 4'h0);
    send_item(ACT_CLR_LOWPWR, 8'h00, 4'h0);
    tick(8'h00, 4'h0);
    tick(8'h00, 4'h0);
  endtask

  // Sleep timer with a short and with the largest timeout
  task automatic test_sleep_timer();
    write_sleep_ticks(32'd2);
    send_item(ACT_SET_PSAVE, 8'h00, 4'h0);
    repeat (5) tick(8'h00, 4'h0);
    send_item(ACT_WAKE, 8'h00, 4'h0);
    repeat (4) tick(8'h00, 4'h0);
    send_item(ACT_CLR_PSAVE, 8'h00, 4'h0);
    tick(8'h00, 4'h0);
    write_sleep_ticks(32'hFFFF_FFFF);
    send_item(ACT_SET_PSAVE, 8'h00, 4'h0);
    repeat (4) tick(8'h00, 4'h0);
    send_item(ACT_CLR_PSAVE, 8'h00, 4'h0);
    tick(8'h00, 4'h0);
  endtask

  // One short, mostly well-formed sequence, or a stretch of noise
  task automatic random_scenario();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_item(ACT_SET_PSAVE, 8'($urandom), 4'($urandom));
        k = $urandom_range(3, 14);
        repeat (k) begin
          if ($urandom_range(0, 7) == 0) send_item(ACT_WAKE, 8'($urandom), 4'($urandom));
          quiet_tick();
        end
        if ($urandom_range(0, 2) != 0)
          send_item(ACT_CLR_PSAVE, 8'($urandom), 4'($urandom));
      end
      3: begin
        send_item(ACT_SET_WRITE, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 3)) quiet_tick();
      end
      4: begin
        send_item(ACT_SET_CLEAR, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 3)) quiet_tick();
      end
      5: begin
        send_item(ACT_SET_LOWPWR, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(2, 5)) quiet_tick();
        send_item(ACT_CLR_LOWPWR, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 3)) quiet_tick();
      end
      6: begin
        tick(8'($urandom_range(1, 255)), 4'($urandom));
        repeat ($urandom_range(1, 3)) quiet_tick();
        send_item(ACT_SET_RESET, 8'($urandom), 4'($urandom));
        repeat ($urandom_range(2, 4)) quiet_tick();
      end
      default: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) quiet_tick();
          else send_item(4'($urandom_range(0, 15)), 8'($urandom), 4'($urandom));
        end
      end
    endcase
  endtask

  // Random traffic over several timeout settings and idling profiles
  task automatic test_random_traffic();
    logic [31:0] ticks_list[6];
    int          stop_at;
    ticks_list = '{32'd0, 32'd1, 32'($urandom_range(2, 8)), 32'hFFFF_FFFF,
                   32'd3, 32'($urandom_range(0, 12))};
    for (int p = 0; p < 6; p++) begin
      write_sleep_ticks(ticks_list[p]);
      tx_idle_on = (p != 0) && (p != 3);
      rx_idle_on = (p != 0) && (p != 4);
      stop_at = n_sent + 220;
      while (n_sent < stop_at) random_scenario();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_len = 300;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_item(4'($urandom_range(1, 8)), 8'($urandom), 4'($urandom));
      else quiet_tick();
    end
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    n_sent       = 0;
    cycles       = 0;
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_hold_len  = 0;
    sh_mode        = MODE_INIT;
    sh_fault       = '0;
    sh_flags       = FLAGS_RESET_VAL;
    sh_sleep_cnt   = '0;
    sh_sleep_ticks = '0;
    sh_restart     = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_mode_walk();
    test_sleep_timer();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
